@@ design/cbor_ihe_pkg.sv @@
// Shared types and constants of the CBOR item head encoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cbor_ihe_pkg;

	// Queue between front and back end.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_ONLY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY  = 1'b1;

	// Event kinds on the input stream.
	typedef enum logic [3:0] {
		KIND_UINT    = 4'd0,
		KIND_NEGINT  = 4'd1,
		KIND_BYTES   = 4'd2,
		KIND_TEXT    = 4'd3,
		KIND_ARRAY   = 4'd4,
		KIND_MAP     = 4'd5,
		KIND_TAG     = 4'd6,
		KIND_NULL    = 4'd7,
		KIND_FLOAT   = 4'd8,
		KIND_DOUBLE  = 4'd9,
		KIND_PAYLOAD = 4'd10
	} kind_t;

	// Major type bytes and fixed lead bytes.
	localparam logic [7:0] MAJOR_UINT   = 8'h00;
	localparam logic [7:0] MAJOR_NEGINT = 8'h20;
	localparam logic [7:0] MAJOR_BYTES  = 8'h40;
	localparam logic [7:0] MAJOR_TEXT   = 8'h60;
	localparam logic [7:0] MAJOR_ARRAY  = 8'h80;
	localparam logic [7:0] MAJOR_MAP    = 8'ha0;
	localparam logic [7:0] MAJOR_TAG    = 8'hc0;
	localparam logic [7:0] LEAD_NULL    = 8'hf6;
	localparam logic [7:0] LEAD_FLOAT   = 8'hfa;
	localparam logic [7:0] LEAD_DOUBLE  = 8'hfb;

	// Additional-information codes for the argument size.
	localparam logic [7:0] AI_IMM_LIMIT = 8'd24;
	localparam logic [7:0] AI_ARG1      = 8'd24;
	localparam logic [7:0] AI_ARG2      = 8'd25;
	localparam logic [7:0] AI_ARG4      = 8'd26;
	localparam logic [7:0] AI_ARG8      = 8'd27;

	// Configuration write request.
	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          data;
	} cfg_wr_t;

	// One classified item: the results it produces, ready to serialize.
	typedef struct packed {
		logic [7:0]  lead;       // first result byte
		logic [63:0] rest;       // following bytes, next one in the top byte
		logic [3:0]  nres;       // number of results, 1 to 9
		logic [3:0]  item_len;   // item_length field of every result
		logic        byte_valid;
		logic        status;
	} entry_t;

endpackage

@@ design/cbor_item_head_encoder.sv @@
// Top level of the CBOR item head encoder: front end, item queue, back end.
// Depends on cbor_ihe_pkg, cbor_ihe_front, cbor_ihe_fifo and cbor_ihe_back.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    tuser kind, tdata values
//   m_*       out        m_tvalid / m_tready    tuser flags, tdata byte/len
//   cfg_*     in         cfg_we                 cfg_index, cfg_wdata
//
// The front end accepts one event per cycle while the four-entry queue has
// room; classification and the capacity check finish in the accept cycle.
// The back end sends one result per cycle from its output register while m_tready
// is high; an item of L encoded bytes gives L results (1 to 9), one in size-only mode or on failure.
// Reset clears the queue, the byte count, the failure flag and restores the
// register defaults. A stall on the output fills the queue, then drops s_tready.
`timescale 1ns / 1ps

module cbor_item_head_encoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cbor_ihe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                          cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [3:0]                           s_tuser,   // kind
	// unsigned_value, signed_value, float_bits, data_byte
	input  logic [199:0]                         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic                                 m_tlast,
	output logic [1:0]                           m_tuser,   // byte_valid, status
	output logic [15:0]                          m_tdata    // out_byte, item_length
);
	import cbor_ihe_pkg::*;

	cfg_wr_t cfg_wr;
	entry_t  push_entry;
	entry_t  head_entry;
	logic    push;
	logic    pop;
	logic    fifo_full;
	logic    fifo_valid;

	// Bundle the configuration write request.
	assign cfg_wr = '{we: cfg_we, idx: cfg_index, data: cfg_wdata};

	cbor_ihe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_wr),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.fifo_full (fifo_full),
		.push      (push),
		.entry     (push_entry)
	);

	cbor_ihe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (fifo_full),
		.pop      (pop),
		.valid    (fifo_valid),
		.rd_entry (head_entry)
	);

	cbor_ihe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata)
	);

endmodule

@@ design/cbor_ihe_front.sv @@
// Front end of the CBOR item head encoder: accepts events, builds the head,
// checks the buffer capacity and holds the configuration. Uses cbor_ihe_pkg.
`timescale 1ns / 1ps

module cbor_ihe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbor_ihe_pkg::cfg_wr_t cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [3:0]            s_tuser,
	input  logic [199:0]          s_tdata,
	input  logic                  fifo_full,
	output logic                  push,
	output cbor_ihe_pkg::entry_t  entry
);
	import cbor_ihe_pkg::*;

	logic        size_only_q;
	logic [31:0] capacity_q;
	logic [31:0] bytes_used_q;
	logic        failed_q;

	logic [63:0] uval;
	logic [63:0] sval;
	logic [63:0] fbits;
	logic [7:0]  dbyte;
	logic [63:0] head_v;
	logic [7:0]  major;
	logic [7:0]  h_lead;
	logic [63:0] h_rest;
	logic [3:0]  h_n;
	logic [7:0]  lead;
	logic [63:0] rest;
	logic [3:0]  n;
	logic        known;
	logic        use_head;
	logic [32:0] sum;
	logic        no_room;
	logic        accept;

	assign uval  = s_tdata[63:0];
	assign sval  = s_tdata[127:64];
	assign fbits = s_tdata[191:128];
	assign dbyte = s_tdata[199:192];

	assign s_tready = !fifo_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && known;

	// Head argument: a negative integer is encoded by its complement.
	assign head_v = (s_tuser == KIND_NEGINT) ? ~sval : uval;

	// Shortest head for the argument.
	always_comb begin
		if (head_v < {56'b0, AI_IMM_LIMIT}) begin
			h_lead = major | {3'b0, head_v[4:0]};
			h_rest = '0;
			h_n    = 4'd1;
		end else if (head_v[63:8] == '0) begin
			h_lead = major | AI_ARG1;
			h_rest = {head_v[7:0], 56'b0};
			h_n    = 4'd2;
		end else if (head_v[63:16] == '0) begin
			h_lead = major | AI_ARG2;
			h_rest = {head_v[15:0], 48'b0};
			h_n    = 4'd3;
		end else if (head_v[63:32] == '0) begin
			h_lead = major | AI_ARG4;
			h_rest = {head_v[31:0], 32'b0};
			h_n    = 4'd5;
		end else begin
			h_lead = major | AI_ARG8;
			h_rest = head_v;
			h_n    = 4'd9;
		end
	end

	// Classify the event by kind.
	always_comb begin
		known    = 1'b1;
		use_head = 1'b0;
		major    = MAJOR_UINT;
		lead     = '0;
		rest     = '0;
		n        = 4'd1;
		unique case (s_tuser)
			KIND_UINT: begin
				use_head = 1'b1;
				major    = MAJOR_UINT;
			end
			KIND_NEGINT: begin
				use_head = 1'b1;
				major    = MAJOR_NEGINT;
			end
			KIND_BYTES: begin
				use_head = 1'b1;
				major    = MAJOR_BYTES;
			end
			KIND_TEXT: begin
				use_head = 1'b1;
				major    = MAJOR_TEXT;
			end
			KIND_ARRAY: begin
				use_head = 1'b1;
				major    = MAJOR_ARRAY;
			end
			KIND_MAP: begin
				use_head = 1'b1;
				major    = MAJOR_MAP;
			end
			KIND_TAG: begin
				use_head = 1'b1;
				major    = MAJOR_TAG;
			end
			KIND_NULL: begin
				lead = LEAD_NULL;
			end
			KIND_FLOAT: begin
				lead = LEAD_FLOAT;
				rest = {fbits[31:0], 32'b0};
				n    = 4'd5;
			end
			KIND_DOUBLE: begin
				lead = LEAD_DOUBLE;
				rest = fbits;
				n    = 4'd9;
			end
			KIND_PAYLOAD: begin
				lead = dbyte;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		if (use_head) begin
			lead = h_lead;
			rest = h_rest;
			n    = h_n;
		end
	end

	// Capacity check against the running byte count.
	assign sum     = {1'b0, bytes_used_q} + {29'b0, n};
	assign no_room = failed_q || (sum > {1'b0, capacity_q});

	// Entry handed to the back end.
	always_comb begin
		entry.lead       = lead;
		entry.rest       = rest;
		entry.nres       = n;
		entry.item_len   = n;
		entry.byte_valid = 1'b1;
		entry.status     = 1'b0;
		if (size_only_q) begin
			entry.lead       = '0;
			entry.nres       = 4'd1;
			entry.byte_valid = 1'b0;
		end else if (no_room) begin
			entry.lead       = '0;
			entry.nres       = 4'd1;
			entry.item_len   = '0;
			entry.byte_valid = 1'b0;
			entry.status     = 1'b1;
		end
	end

	// Configuration and buffer accounting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_only_q  <= 1'b0;
			capacity_q   <= 32'hffff_ffff;
			bytes_used_q <= '0;
			failed_q     <= 1'b0;
		end else if (cfg.we) begin
			unique case (cfg.idx)
				CFG_IDX_SIZE_ONLY: begin
					size_only_q <= cfg.data[0];
				end
				CFG_IDX_CAPACITY: begin
					capacity_q   <= cfg.data;
					bytes_used_q <= '0;
					failed_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (push && !size_only_q) begin
			if (no_room) begin
				failed_q <= 1'b1;
			end else begin
				bytes_used_q <= sum[31:0];
			end
		end
	end

endmodule

@@ design/cbor_ihe_fifo.sv @@
// Short queue of classified items between front and back end.
// Uses entry_t and the depth constants of cbor_ihe_pkg.
`timescale 1ns / 1ps

module cbor_ihe_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cbor_ihe_pkg::entry_t wr_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output cbor_ihe_pkg::entry_t rd_entry
);
	import cbor_ihe_pkg::*;

	entry_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;

	assign full     = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign valid    = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/cbor_ihe_back.sv @@
// Back end of the CBOR item head encoder: takes items from the queue and
// sends their results, one per cycle while m_tready is high, from an output register. Uses cbor_ihe_pkg.
`timescale 1ns / 1ps

module cbor_ihe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fifo_valid,
	input  cbor_ihe_pkg::entry_t fifo_entry,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_tlast,
	output logic [1:0]           m_tuser,   // byte_valid, status
	output logic [15:0]          m_tdata    // out_byte, item_length, zero fill
);
	import cbor_ihe_pkg::*;

	logic        valid_q;
	logic [3:0]  left_q;
	logic [7:0]  byte_q;
	logic [63:0] rest_q;
	logic [3:0]  len_q;
	logic        bv_q;
	logic        st_q;
	logic        is_last;
	logic        load;
	logic        advance;

	assign is_last = (left_q == 4'd1);
	assign load    = !valid_q || (m_tready && is_last);
	assign advance = valid_q && m_tready && !is_last;
	assign pop     = load && fifo_valid;

	assign m_tvalid = valid_q;
	assign m_tlast  = is_last;
	assign m_tuser  = {st_q, bv_q};
	assign m_tdata  = {4'b0, len_q, byte_q};

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= 4'd1;
		end else if (load) begin
			valid_q <= fifo_valid;
			left_q  <= fifo_entry.nres;
		end else if (advance) begin
			left_q <= left_q - 4'd1;
		end
	end

	// Result payload: load a new item or shift out its next byte.
	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q <= fifo_entry.lead;
			rest_q <= fifo_entry.rest;
			len_q  <= fifo_entry.item_len;
			bv_q   <= fifo_entry.byte_valid;
			st_q   <= fifo_entry.status;
		end else if (advance) begin
			byte_q <= rest_q[63:56];
			rest_q <= {rest_q[55:0], 8'b0};
		end
	end

	// A result without a byte is always the only result of its item.
	a_nobyte_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("result without a byte is not last");

	// A failure result carries no length and no byte.
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[11:8] == 4'd0 && !m_tuser[0]))
		else $error("failure result has length or byte");

	// Emitted bytes carry a nonzero item length, never above nine.
	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[11:8] != 4'd0 && m_tdata[11:8] <= 4'd9))
		else $error("emitted byte with bad item length");

	// A stalled multi-byte item keeps its remaining count.
	a_hold_left: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(left_q))
		else $error("remaining count moved under stall");

endmodule
